/* design/decimal_literal_parser_assert.svh */
// assertion macros shared by the decimal literal parser modules
`ifndef DECIMAL_LITERAL_PARSER_ASSERT_SVH
`define DECIMAL_LITERAL_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define DLP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dlp check failed");
// next-cycle implication, checked out of reset
`define DLP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dlp check failed");
`else
`define DLP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DLP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* design/dlp_pkg.sv */
// types and constants for the decimal literal parser
package dlp_pkg;

  // character classes produced by the front end
  typedef enum logic [3:0] {
    CL_WS,
    CL_PLUS,
    CL_MINUS,
    CL_DIGIT,
    CL_POINT,
    CL_EXP,
    CL_SUFFIX,
    CL_NUL,
    CL_OTHER
  } char_class_t;

  // one queued word: class plus digit value
  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
  } char_word_t;

  // parser phases
  typedef enum logic [3:0] {
    PH_LEAD,
    PH_SIGN,
    PH_INT,
    PH_POINT,
    PH_FRAC,
    PH_ESTART,
    PH_ESIGN,
    PH_EDIG,
    PH_TRAIL,
    PH_ERR
  } phase_t;

  // error codes as reported
  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_POINT,
    ERR_NODIG,
    ERR_EXP,
    ERR_SUFFIX,
    ERR_CHAR
  } err_t;

  // per-word actions of the parser
  typedef struct packed {
    logic int_en;
    logic frac_en;
    logic exp_en;
    logic set_minus;
    logic set_exp_neg;
    logic set_digit;
    logic ok;
    err_t fail;
  } act_t;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UL    = 8'h4C;
  localparam logic [7:0] CH_LL    = 8'h6C;

  // field widths
  localparam int CHAR_W      = 8;
  localparam int ACC_W       = 64;
  localparam int COUNT_W     = 5;
  localparam int EXP_ACC_W   = 14;
  localparam int EXP_W       = 15;
  localparam int OUT_TDATA_W = 160;

  localparam logic [EXP_ACC_W-1:0] EXP_LIMIT = 14'd9999;

endpackage

/* design/dlp_front.sv */
// front end: accepts characters and classifies them into queue words
module dlp_front (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dlp_pkg::CHAR_W-1:0]  in_char,
  input  logic                        q_full,
  output logic                        push,
  output dlp_pkg::char_word_t         push_word
);
  import dlp_pkg::*;

  // map a character code to its class
  function automatic char_class_t classify(input logic [CHAR_W-1:0] c);
    char_class_t r;
    if (c == CH_NUL) r = CL_NUL;
    else if (c == CH_SPACE || (c inside {[CH_TAB:CH_CR]})) r = CL_WS;
    else if (c inside {[CH_ZERO:CH_NINE]}) r = CL_DIGIT;
    else if (c == CH_PLUS) r = CL_PLUS;
    else if (c == CH_MINUS) r = CL_MINUS;
    else if (c == CH_POINT) r = CL_POINT;
    else if (c inside {CH_UE, CH_LE}) r = CL_EXP;
    else if (c inside {CH_UF, CH_LF, CH_UL, CH_LL}) r = CL_SUFFIX;
    else r = CL_OTHER;
    return r;
  endfunction

  // take a word whenever the queue has room
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // digit value sits in the low nibble of the code
  always_comb begin
    push_word.cls   = classify(in_char);
    push_word.digit = in_char[3:0];
  end

endmodule

/* design/dlp_queue.sv */
// short queue of classified words between front and back
`include "decimal_literal_parser_assert.svh"
module dlp_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dlp_pkg::char_word_t push_word,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output dlp_pkg::char_word_t head_word
);
  import dlp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  char_word_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_word  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  `DLP_ASSERT_IMP(a_no_overflow, clk, rst, push, count != CNT_W'(DEPTH))
  `DLP_ASSERT_IMP(a_no_underflow, clk, rst, pop, count != '0)
  `DLP_ASSERT_NEXT(a_count_track, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

/* design/dlp_back.sv */
// back end: parser state machine, accumulators and result register
`include "decimal_literal_parser_assert.svh"
module dlp_back #(
  parameter int MAX_FRACTION_DIGITS = 19
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              word_valid,
  input  dlp_pkg::char_word_t               word,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dlp_pkg::OUT_TDATA_W-1:0]   out_data
);
  import dlp_pkg::*;

  localparam logic [COUNT_W-1:0] MAX_KEPT = COUNT_W'(MAX_FRACTION_DIGITS);

  phase_t               phase, phase_next;
  logic                 minus_seen;
  logic [ACC_W-1:0]     int_acc;
  logic [ACC_W-1:0]     frac_acc;
  logic [COUNT_W-1:0]   frac_cnt;
  logic                 exp_neg;
  logic [EXP_ACC_W-1:0] exp_acc;
  logic                 digit_seen;
  err_t                 err;
  logic                 lost;

  act_t                 act;
  logic                 is_nul;
  logic                 out_free;
  logic [ACC_W+3:0]     int_wide;
  logic [EXP_ACC_W+2:0] exp_wide;
  logic [ACC_W-1:0]     frac_new;
  logic                 good;
  err_t                 err_final;
  logic [EXP_W-1:0]     exp_signed;

  // character that follows the number body
  function automatic phase_t after_phase(input char_class_t c, input logic allow_exp);
    phase_t p;
    if (allow_exp && c == CL_EXP) p = PH_ESTART;
    else if (c == CL_WS) p = PH_TRAIL;
    else if (c == CL_NUL) p = PH_LEAD;
    else p = PH_ERR;
    return p;
  endfunction

  function automatic err_t after_err(input char_class_t c, input logic allow_exp);
    err_t e;
    if (allow_exp && c == CL_EXP) e = ERR_NONE;
    else if (c == CL_SUFFIX) e = ERR_SUFFIX;
    else if (c == CL_WS || c == CL_NUL) e = ERR_NONE;
    else e = ERR_CHAR;
    return e;
  endfunction

  // a terminator needs the result register free
  assign is_nul   = (word.cls == CL_NUL);
  assign out_free = !out_valid || out_ready;
  assign pop      = word_valid && (!is_nul || out_free);

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_LEAD: begin
        if (word.cls == CL_WS) phase_next = PH_LEAD;
        else if (word.cls inside {CL_PLUS, CL_MINUS}) phase_next = PH_SIGN;
        else if (word.cls == CL_DIGIT) phase_next = PH_INT;
        else if (word.cls == CL_POINT) phase_next = PH_POINT;
        else phase_next = PH_ERR;
      end
      PH_SIGN: begin
        if (word.cls == CL_DIGIT) phase_next = PH_INT;
        else if (word.cls == CL_POINT) phase_next = PH_POINT;
        else phase_next = PH_ERR;
      end
      PH_INT: begin
        if (word.cls == CL_DIGIT) phase_next = PH_INT;
        else if (word.cls == CL_POINT) phase_next = PH_POINT;
        else phase_next = after_phase(word.cls, 1'b1);
      end
      PH_POINT: begin
        if (word.cls == CL_DIGIT) phase_next = PH_FRAC;
        else if (!digit_seen) phase_next = PH_ERR;
        else phase_next = after_phase(word.cls, 1'b1);
      end
      PH_FRAC: begin
        if (word.cls == CL_DIGIT) phase_next = PH_FRAC;
        else phase_next = after_phase(word.cls, 1'b1);
      end
      PH_ESTART: begin
        if (word.cls inside {CL_PLUS, CL_MINUS}) phase_next = PH_ESIGN;
        else if (word.cls == CL_DIGIT) phase_next = PH_EDIG;
        else phase_next = PH_ERR;
      end
      PH_ESIGN: begin
        if (word.cls == CL_DIGIT) phase_next = PH_EDIG;
        else phase_next = PH_ERR;
      end
      PH_EDIG: begin
        if (word.cls == CL_DIGIT) phase_next = PH_EDIG;
        else phase_next = after_phase(word.cls, 1'b0);
      end
      PH_TRAIL: begin
        if (word.cls == CL_NUL || word.cls == CL_WS) phase_next = PH_TRAIL;
        else phase_next = PH_ERR;
      end
      PH_ERR:  phase_next = PH_ERR;
      default: phase_next = PH_ERR;
    endcase
  end

  // per-word actions
  always_comb begin
    act = '0;
    case (phase)
      PH_LEAD, PH_SIGN: begin
        if (phase == PH_LEAD && word.cls == CL_WS) begin
          act = '0;
        end else if (phase == PH_LEAD && word.cls inside {CL_PLUS, CL_MINUS}) begin
          act.set_minus = 1'b1;
        end else if (word.cls == CL_DIGIT) begin
          act.int_en    = 1'b1;
          act.set_digit = 1'b1;
        end else if (word.cls != CL_POINT) begin
          act.fail = ERR_NODIG;
        end
      end
      PH_INT: begin
        if (word.cls == CL_DIGIT) begin
          act.int_en = 1'b1;
        end else if (word.cls != CL_POINT) begin
          act.fail = after_err(word.cls, 1'b1);
          act.ok   = is_nul;
        end
      end
      PH_POINT: begin
        if (word.cls == CL_DIGIT) begin
          act.frac_en   = 1'b1;
          act.set_digit = 1'b1;
        end else if (!digit_seen) begin
          act.fail = ERR_POINT;
        end else begin
          act.fail = after_err(word.cls, 1'b1);
          act.ok   = is_nul;
        end
      end
      PH_FRAC: begin
        if (word.cls == CL_DIGIT) begin
          act.frac_en = 1'b1;
        end else begin
          act.fail = after_err(word.cls, 1'b1);
          act.ok   = is_nul;
        end
      end
      PH_ESTART, PH_ESIGN: begin
        if (phase == PH_ESTART && word.cls inside {CL_PLUS, CL_MINUS}) begin
          act.set_exp_neg = 1'b1;
        end else if (word.cls == CL_DIGIT) begin
          act.exp_en = 1'b1;
        end else begin
          act.fail = ERR_EXP;
        end
      end
      PH_EDIG: begin
        if (word.cls == CL_DIGIT) begin
          act.exp_en = 1'b1;
        end else begin
          act.fail = after_err(word.cls, 1'b0);
          act.ok   = is_nul;
        end
      end
      PH_TRAIL: begin
        if (is_nul) begin
          act.ok = 1'b1;
        end else if (word.cls != CL_WS) begin
          act.fail = ERR_CHAR;
        end
      end
      PH_ERR:  act = '0;
      default: act = '0;
    endcase
  end

  // times ten plus digit datapaths
  assign int_wide = ({4'b0, int_acc} << 3) + ({4'b0, int_acc} << 1)
                  + {{ACC_W{1'b0}}, word.digit};
  assign frac_new = (frac_acc << 3) + (frac_acc << 1) + {{(ACC_W-4){1'b0}}, word.digit};
  assign exp_wide = ({3'b0, exp_acc} << 3) + ({3'b0, exp_acc} << 1)
                  + {{(EXP_ACC_W-1){1'b0}}, word.digit};

  // result of a terminator
  assign good       = act.ok && (err == ERR_NONE);
  assign exp_signed = exp_neg ? EXP_W'(-{1'b0, exp_acc}) : {1'b0, exp_acc};
  always_comb begin
    if (good) err_final = ERR_NONE;
    else if (err != ERR_NONE) err_final = err;
    else if (act.fail != ERR_NONE) err_final = act.fail;
    else err_final = ERR_CHAR;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst || (pop && is_nul)) begin
      phase      <= PH_LEAD;
      minus_seen <= 1'b0;
      int_acc    <= '0;
      frac_acc   <= '0;
      frac_cnt   <= '0;
      exp_neg    <= 1'b0;
      exp_acc    <= '0;
      digit_seen <= 1'b0;
      err        <= ERR_NONE;
      lost       <= 1'b0;
    end else if (pop) begin
      phase <= phase_next;
      if (act.set_minus) minus_seen <= (word.cls == CL_MINUS);
      if (act.set_exp_neg) exp_neg <= (word.cls == CL_MINUS);
      if (act.set_digit) digit_seen <= 1'b1;
      if (act.fail != ERR_NONE) err <= act.fail;
      if (act.int_en) begin
        if (int_wide[ACC_W+3:ACC_W] != 4'b0) begin
          int_acc <= '1;
          lost    <= 1'b1;
        end else begin
          int_acc <= int_wide[ACC_W-1:0];
        end
      end
      if (act.frac_en) begin
        if (frac_cnt < MAX_KEPT) begin
          frac_acc <= frac_new;
          frac_cnt <= frac_cnt + 1'b1;
        end else begin
          lost <= 1'b1;
        end
      end
      if (act.exp_en) begin
        if (exp_wide > {3'b0, EXP_LIMIT}) begin
          exp_acc <= EXP_LIMIT;
          lost    <= 1'b1;
        end else begin
          exp_acc <= exp_wide[EXP_ACC_W-1:0];
        end
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && is_nul) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_nul) begin
      if (good) begin
        out_data <= {7'b0, err_final, lost, exp_signed, frac_cnt, frac_acc, int_acc,
                     minus_seen};
      end else begin
        out_data <= {7'b0, err_final, {(OUT_TDATA_W-10){1'b0}}};
      end
    end
  end

  `DLP_ASSERT_NEXT(a_nul_gives_word, clk, rst, pop && is_nul, out_valid)
  `DLP_ASSERT_IMP(a_err_zero_fields, clk, rst, out_valid && out_data[152:150] != ERR_NONE,
                  out_data[149:0] == '0)
  `DLP_ASSERT_IMP(a_frac_bound, clk, rst, phase != PH_LEAD, frac_cnt <= MAX_KEPT)
  `DLP_ASSERT_IMP(a_exp_bound, clk, rst, phase != PH_LEAD, exp_acc <= EXP_LIMIT)

endmodule

/* design/decimal_literal_parser.sv */
// top level of the decimal literal parser
// Parses an ASCII decimal floating-point literal one character per word, a NUL
// ending each token. The parser takes one character every clock cycle while the
// queue has room; the sustained rate is set by the back-end state machine, which
// consumes one queued word per cycle, short of a NUL stall, with a single
// times-ten-plus-digit add on each accumulator. A token's NUL passes through the
// queue to the back end, which then registers the token's result word. It waits
// in an output register while further characters keep flowing into the queue.
// Only a NUL that reaches the queue head while the previous result word is still
// held stalls the back end. Error results carry only the error code.
module decimal_literal_parser #(
  parameter int MAX_FRACTION_DIGITS = 19,
  parameter int QUEUE_DEPTH         = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // char_code[7:0]
  input  logic [dlp_pkg::CHAR_W-1:0]          s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // is_negative[0], integer_digits[64:1], fraction_digits_value[128:65],
  // fraction_count[133:129], decimal_exponent[148:134], inexact[149],
  // error_code[152:150], zero[159:153]
  output logic [dlp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import dlp_pkg::*;

  logic       q_full;
  logic       push;
  char_word_t push_word;
  logic       pop;
  logic       head_valid;
  char_word_t head_word;

  // classify incoming characters
  dlp_front u_front (
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_char   (s_axis_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_word (push_word)
  );

  // decouple front and back
  dlp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_word  (push_word),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_word  (head_word)
  );

  // parse and emit results
  dlp_back #(
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .word_valid (head_valid),
    .word       (head_word),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata)
  );

endmodule

/* test/dlp_result_check.sv */
// result checker for the decimal literal parser: mirrors the parse and compares result words
`timescale 1ns / 1ps

module dlp_result_check (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [dlp_pkg::CHAR_W-1:0]      s_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [dlp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output int                              fail_count,
  output int                              results_due
);
  import dlp_pkg::*;

  localparam int          FRAC_KEEP = 19;
  // largest value that can still take another digit without overflow
  localparam logic [63:0] INT_TOP   = 64'h1999_9999_9999_9999;

  // one result word, msb first so it overlays m_axis_tdata directly
  typedef struct packed {
    logic [6:0]         pad;
    err_t               code;
    logic               inexact;
    logic [EXP_W-1:0]   exponent;
    logic [COUNT_W-1:0] frac_count;
    logic [ACC_W-1:0]   frac_digits;
    logic [ACC_W-1:0]   int_part;
    logic               negative;
  } literal_result_t;

  literal_result_t      predicted_literals[$];
  int                   mismatch_total = 0;
  int                   literals_due = 0;

  // mirrored parse state
  phase_t               ph;
  logic                 neg_sign;
  logic [ACC_W-1:0]     int_value;
  logic [ACC_W-1:0]     frac_value;
  logic [COUNT_W-1:0]   frac_kept;
  logic                 exp_minus;
  int unsigned          exp_value;
  logic                 have_digit;
  err_t                 first_err;
  logic                 rounded;

  assign fail_count  = mismatch_total;
  assign results_due = literals_due;

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic void clear_parse();
    ph         = PH_LEAD;
    neg_sign   = 1'b0;
    int_value  = '0;
    frac_value = '0;
    frac_kept  = '0;
    exp_minus  = 1'b0;
    exp_value  = 0;
    have_digit = 1'b0;
    first_err  = ERR_NONE;
    rounded    = 1'b0;
  endfunction

  function automatic void latch_error(input err_t code);
    first_err = code;
    ph        = PH_ERR;
  endfunction

  // integer part saturates at all ones
  function automatic void add_int_digit(input logic [3:0] d);
    if (int_value > INT_TOP || (int_value == INT_TOP && d > 4'd5)) begin
      int_value = '1;
      rounded   = 1'b1;
    end else begin
      int_value = int_value * 10 + d;
    end
  endfunction

  // fraction digits past the kept count are dropped
  function automatic void add_frac_digit(input logic [3:0] d);
    if (frac_kept < FRAC_KEEP) begin
      frac_value = frac_value * 10 + d;
      frac_kept  = frac_kept + 1'b1;
    end else begin
      rounded = 1'b1;
    end
  endfunction

  function automatic void add_exp_digit(input logic [3:0] d);
    int unsigned v;
    v = exp_value * 10 + d;
    if (v > EXP_LIMIT) begin
      v       = EXP_LIMIT;
      rounded = 1'b1;
    end
    exp_value = v;
  endfunction

  // character following the number body; returns 1 when the token ends cleanly
  function automatic logic end_of_body(input logic [7:0] c, input logic exp_allowed);
    end_of_body = 1'b0;
    if (exp_allowed && (c == CH_UE || c == CH_LE)) begin
      ph = PH_ESTART;
    end else if (c == CH_UF || c == CH_LF || c == CH_UL || c == CH_LL) begin
      latch_error(ERR_SUFFIX);
    end else if (is_space(c)) begin
      ph = PH_TRAIL;
    end else if (c == CH_NUL) begin
      end_of_body = 1'b1;
    end else begin
      latch_error(ERR_CHAR);
    end
  endfunction

  // advance the mirror by one character, queue a result on nul
  task automatic take_char(input logic [7:0] c);
    logic            done;
    logic [3:0]      d;
    literal_result_t lit;
    done = 1'b0;
    d    = 4'(c - CH_ZERO);
    case (ph)
      PH_LEAD, PH_SIGN: begin
        if (!(ph == PH_LEAD && is_space(c))) begin
          if (ph == PH_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
            neg_sign = (c == CH_MINUS);
            ph       = PH_SIGN;
          end else if (is_digit(c)) begin
            have_digit = 1'b1;
            add_int_digit(d);
            ph = PH_INT;
          end else if (c == CH_POINT) begin
            ph = PH_POINT;
          end else begin
            latch_error(ERR_NODIG);
          end
        end
      end
      PH_INT: begin
        if (is_digit(c)) add_int_digit(d);
        else if (c == CH_POINT) ph = PH_POINT;
        else done = end_of_body(c, 1'b1);
      end
      PH_POINT: begin
        if (is_digit(c)) begin
          have_digit = 1'b1;
          add_frac_digit(d);
          ph = PH_FRAC;
        end else if (!have_digit) begin
          latch_error(ERR_POINT);
        end else begin
          done = end_of_body(c, 1'b1);
        end
      end
      PH_FRAC: begin
        if (is_digit(c)) add_frac_digit(d);
        else done = end_of_body(c, 1'b1);
      end
      PH_ESTART, PH_ESIGN: begin
        if (ph == PH_ESTART && (c == CH_PLUS || c == CH_MINUS)) begin
          exp_minus = (c == CH_MINUS);
          ph        = PH_ESIGN;
        end else if (is_digit(c)) begin
          add_exp_digit(d);
          ph = PH_EDIG;
        end else begin
          latch_error(ERR_EXP);
        end
      end
      PH_EDIG: begin
        if (is_digit(c)) add_exp_digit(d);
        else done = end_of_body(c, 1'b0);
      end
      PH_TRAIL: begin
        if (c == CH_NUL) done = 1'b1;
        else if (!is_space(c)) latch_error(ERR_CHAR);
      end
      default: ;
    endcase

    if (c == CH_NUL) begin
      lit = '0;
      if (done && first_err == ERR_NONE) begin
        lit.negative    = neg_sign;
        lit.int_part    = int_value;
        lit.frac_digits = frac_value;
        lit.frac_count  = frac_kept;
        lit.exponent    = exp_minus ? EXP_W'(-exp_value) : EXP_W'(exp_value);
        lit.inexact     = rounded;
      end else begin
        lit.code = (first_err != ERR_NONE) ? first_err : ERR_CHAR;
      end
      predicted_literals.push_back(lit);
      clear_parse();
    end
  endtask

  task automatic compare_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d (0x%0h) actual %0d (0x%0h)",
               $time, what, want, want, got, got);
      mismatch_total++;
    end
  endtask

  task automatic check_literal(input literal_result_t got);
    literal_result_t want;
    if (predicted_literals.size() == 0) begin
      $display("%0t: result word expected none actual 0x%0h", $time, got);
      mismatch_total++;
    end else begin
      want = predicted_literals.pop_front();
      compare_field("is_negative", 64'(want.negative), 64'(got.negative));
      compare_field("integer_digits", want.int_part, got.int_part);
      compare_field("fraction_digits_value", want.frac_digits, got.frac_digits);
      compare_field("fraction_count", 64'(want.frac_count), 64'(got.frac_count));
      compare_field("decimal_exponent", 64'(want.exponent), 64'(got.exponent));
      compare_field("inexact", 64'(want.inexact), 64'(got.inexact));
      compare_field("error_code", 64'(want.code), 64'(got.code));
      compare_field("padding", 64'(want.pad), 64'(got.pad));
    end
  endtask

  // sample both channels at each edge, results before characters
  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      predicted_literals.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_literal(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) take_char(s_axis_tdata);
    end
    literals_due = predicted_literals.size();
  end

endmodule

/* test/tb_top.sv */
// testbench top for the decimal literal parser: character stimulus, back pressure, verdict
`timescale 1ns / 1ps

module tb_top;
  import dlp_pkg::*;

  localparam int STALL_LIMIT     = 5000;
  localparam int CHARS_PER_PHASE = 440;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [CHAR_W-1:0]      s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int                     fail_count;
  int                     results_due;
  int unsigned            send_idle_pct = 6;
  int unsigned            recv_idle_pct = 84;
  int                     stall_cycles = 0;
  int                     chars_sent = 0;
  logic [7:0]             literal_chars[$];

  always #6 clk = ~clk;

  decimal_literal_parser DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  dlp_result_check result_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .results_due   (results_due)
  );

  // receiver back pressure
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic put_text(input string s);
    foreach (s[i]) literal_chars.push_back(s[i]);
  endtask

  task automatic put_digits(input int n);
    repeat (n) literal_chars.push_back(8'(CH_ZERO + $urandom_range(9)));
  endtask

  task automatic put_space();
    int w;
    w = $urandom_range(0, 5);
    literal_chars.push_back((w == 5) ? CH_SPACE : 8'(CH_TAB + w));
  endtask

  // mostly well formed literals with random content, some noise and damage
  task automatic put_random_token();
    int       head;
    int       pos;
    int       r;
    logic     int_digits;
    logic [7:0] sfx[4];
    sfx  = '{CH_UF, CH_LF, CH_UL, CH_LL};
    head = literal_chars.size();
    int_digits = 1'b1;
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(0, 8)) literal_chars.push_back(8'($urandom_range(1, 255)));
    end else begin
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) put_space();
      r = $urandom_range(2);
      if (r == 1) literal_chars.push_back(CH_PLUS);
      else if (r == 2) literal_chars.push_back(CH_MINUS);
      // integer part, sometimes right at the saturation edge
      r = $urandom_range(99);
      if (r < 15) begin
        int_digits = 1'b0;
      end else if (r < 22) begin
        put_text("1844674407370955161");
        put_digits($urandom_range(1, 2));
      end else if (r < 30) begin
        put_digits($urandom_range(19, 22));
      end else begin
        put_digits($urandom_range(1, 6));
      end
      // point and fraction
      if ($urandom_range(99) < (int_digits ? 45 : 85)) begin
        literal_chars.push_back(CH_POINT);
        r = $urandom_range(99);
        if (r < 15) ;
        else if (r < 32) put_digits($urandom_range(18, 23));
        else put_digits($urandom_range(1, 5));
      end
      // exponent
      if ($urandom_range(99) < 30) begin
        literal_chars.push_back($urandom_range(1) ? CH_UE : CH_LE);
        r = $urandom_range(2);
        if (r == 1) literal_chars.push_back(CH_PLUS);
        else if (r == 2) literal_chars.push_back(CH_MINUS);
        if ($urandom_range(99) >= 5) put_digits($urandom_range(1, 6));
      end
      if ($urandom_range(99) < 6) literal_chars.push_back(sfx[$urandom_range(3)]);
      if ($urandom_range(99) < 15) repeat ($urandom_range(1, 3)) put_space();
      // damage one character
      if ($urandom_range(99) < 10 && literal_chars.size() > head) begin
        pos = $urandom_range(head, literal_chars.size() - 1);
        literal_chars[pos] = 8'($urandom_range(1, 255));
      end
    end
    literal_chars.push_back(CH_NUL);
  endtask

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_queued();
    while (literal_chars.size() != 0) send_char(literal_chars.pop_front());
  endtask

  initial begin
    int phase_start;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed tokens
    literal_chars.push_back(CH_NUL);                        // empty token
    put_text(".");            literal_chars.push_back(CH_NUL);
    put_text("-");            literal_chars.push_back(CH_NUL);
    put_text("5.");           literal_chars.push_back(CH_NUL);
    put_text("1E");           literal_chars.push_back(CH_NUL);
    put_text("-.5e-7");       literal_chars.push_back(CH_NUL);
    put_text("2.5f");         literal_chars.push_back(CH_NUL);
    put_text("9 L");          literal_chars.push_back(CH_NUL);
    put_text("3x");           literal_chars.push_back(CH_NUL);
    for (int w = CH_TAB; w <= CH_CR; w++) literal_chars.push_back(8'(w));
    put_text("+7 ");          literal_chars.push_back(CH_NUL);
    literal_chars.push_back(8'hFF); literal_chars.push_back(CH_NUL);
    put_text("0");            literal_chars.push_back(8'h80);
    literal_chars.push_back(CH_NUL);
    put_text("0.12345678901234567890"); literal_chars.push_back(CH_NUL);
    send_queued();

    // random tokens under three idling profiles
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 6 : (p == 1) ? 84 : 0;
      recv_idle_pct = (p == 0) ? 84 : (p == 1) ? 6 : 0;
      phase_start = chars_sent;
      while (chars_sent - phase_start < CHARS_PER_PHASE) begin
        put_random_token();
        send_queued();
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain outstanding results, then a short tail
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
